// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define U8D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8d: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define U8D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8d: next-cycle check failed");

`endif

// ===== sv/u8d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants
// Command word passed from the byte classifier to the result sequencer.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned CP_W = 31;

    // replacement character '?'
    localparam logic [CP_W-1:0] REPL_CHAR = 31'd63;

    // expected sequence length codes
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;
    localparam logic [2:0] LEN_5    = 3'd5;
    localparam logic [2:0] LEN_6    = 3'd6;

    // One command: repl_cnt '?' results, then an optional tail result.
    typedef struct packed {
        logic [2:0]      repl_cnt;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_eos;
    } t_cmd;

endpackage
`default_nettype wire

// ===== sv/u8d_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_front: byte classifier
// Tracks the pending sequence and turns each byte into at most one command.
// ----------------------------------------------------------------------------
module u8d_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_q_full,
    output logic                o_push,
    output u8d_pkg::t_cmd       o_cmd
);
    import u8d_pkg::*;

    logic [2:0]      r_exp;
    logic [2:0]      r_taken;
    logic [CP_W-1:0] r_acc;
    logic [2:0]      n_exp;
    logic [2:0]      n_taken;
    logic [CP_W-1:0] n_acc;
    logic [CP_W-1:0] acc_shift;
    logic [2:0]      taken_inc;
    logic            as_lead;
    logic            accept;
    t_cmd            cmd;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign acc_shift  = {r_acc[CP_W-7:0], i_in_byte[5:0]};
    assign taken_inc  = r_taken + 3'd1;

    always_comb begin
        n_exp   = r_exp;
        n_taken = r_taken;
        n_acc   = r_acc;
        cmd     = '0;
        as_lead = 1'b1;
        if (r_exp != LEN_NONE) begin
            if (i_in_byte[7:6] == 2'b10) begin
                as_lead = 1'b0;
                if (taken_inc >= r_exp) begin
                    cmd.has_tail = 1'b1;
                    cmd.tail_cp  = acc_shift;
                    n_exp        = LEN_NONE;
                    n_taken      = 3'd0;
                    n_acc        = '0;
                end else begin
                    n_taken = taken_inc;
                    n_acc   = acc_shift;
                end
            end else begin
                // broken sequence: one '?' per byte already taken
                cmd.repl_cnt = r_taken;
                n_exp        = LEN_NONE;
                n_taken      = 3'd0;
                n_acc        = '0;
            end
        end
        if (as_lead) begin
            if (i_in_byte == 8'h00) begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = '0;
                cmd.tail_eos = 1'b1;
            end else if (!i_in_byte[7]) begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = {23'd0, i_in_byte};
            end else if (!i_in_byte[6]) begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = REPL_CHAR;
            end else if (!i_in_byte[5]) begin
                n_exp   = LEN_2;
                n_taken = 3'd1;
                n_acc   = {26'd0, i_in_byte[4:0]};
            end else if (!i_in_byte[4]) begin
                n_exp   = LEN_3;
                n_taken = 3'd1;
                n_acc   = {27'd0, i_in_byte[3:0]};
            end else if (!i_in_byte[3]) begin
                n_exp   = LEN_4;
                n_taken = 3'd1;
                n_acc   = {28'd0, i_in_byte[2:0]};
            end else if (!i_in_byte[2]) begin
                n_exp   = LEN_5;
                n_taken = 3'd1;
                n_acc   = {29'd0, i_in_byte[1:0]};
            end else if (!i_in_byte[1]) begin
                n_exp   = LEN_6;
                n_taken = 3'd1;
                n_acc   = {30'd0, i_in_byte[0]};
            end else begin
                cmd.has_tail = 1'b1;
                cmd.tail_cp  = REPL_CHAR;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && ((cmd.repl_cnt != 3'd0) || cmd.has_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp   <= LEN_NONE;
            r_taken <= 3'd0;
            r_acc   <= '0;
        end else if (accept) begin
            r_exp   <= n_exp;
            r_taken <= n_taken;
            r_acc   <= n_acc;
        end
    end

endmodule
`default_nettype wire

// ===== sv/u8d_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_queue: command queue
// Small register queue that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module u8d_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire u8d_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_valid,
    output logic                o_full,
    output u8d_pkg::t_cmd       o_cmd
);
    import u8d_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/u8d_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_back: result sequencer
// Expands the head command into results, one per cycle unless the output stalls, into an output reg.
// ----------------------------------------------------------------------------
module u8d_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire u8d_pkg::t_cmd            i_cmd,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [u8d_pkg::CP_W-1:0]      o_code_point,
    output logic                          o_end_of_string,
    output logic                          o_last_of_run
);
    import u8d_pkg::*;

    logic [2:0]      r_sent;
    logic            r_out_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_eos;
    logic            r_last;
    logic            can_load;
    logic            emit;
    logic            in_repl;
    logic            is_last;
    logic [2:0]      sent_inc;
    logic [CP_W-1:0] n_cp;
    logic            n_eos;

    assign can_load = !r_out_valid || i_out_ready;
    assign emit     = i_q_valid && can_load;
    assign sent_inc = r_sent + 3'd1;
    assign in_repl  = (r_sent < i_cmd.repl_cnt);
    assign is_last  = in_repl ? ((sent_inc == i_cmd.repl_cnt) && !i_cmd.has_tail) : 1'b1;
    assign n_cp     = in_repl ? REPL_CHAR : i_cmd.tail_cp;
    assign n_eos    = in_repl ? 1'b0 : i_cmd.tail_eos;
    assign o_pop    = emit && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_load) begin
                r_out_valid <= i_q_valid;
            end
            if (emit) begin
                r_sent <= is_last ? 3'd0 : sent_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_cp   <= n_cp;
            r_eos  <= n_eos;
            r_last <= is_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_code_point    = r_cp;
    assign o_end_of_string = r_eos;
    assign o_last_of_run   = r_last;

endmodule
`default_nettype wire

// ===== sv/utf8_to_code_point_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_core: six-byte UTF-8 decoder
// Decodes a zero-terminated byte stream into code points, '?' on errors.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  in       | i_in_valid / o_in_ready    | i_in_byte
//  out      | o_out_valid / i_out_ready  | o_code_point, o_end_of_string,
//           |                            | o_last_of_run
//
//  One byte is taken per cycle while the command queue has room.
//  A byte yields 0 to 6 results; the sequencer sends one result per cycle
//  while the output register can load, that is, unless the output stalls.
//  An input's results pass through the command queue, then the output reg.
//  Synchronous active-low reset clears sequence state, queue and output.
//  Input stalls only when the queue is full; output stalls back up into it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_to_code_point_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [7:0]               i_in_byte,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [u8d_pkg::CP_W-1:0]      o_code_point,
    output logic                          o_end_of_string,
    output logic                          o_last_of_run
);
    import u8d_pkg::*;

    // classifier -> queue
    logic q_push;
    logic q_full;
    t_cmd push_cmd;
    // queue -> sequencer
    logic q_valid;
    logic q_pop;
    t_cmd head_cmd;
    // end marker shape: final result of its byte, zero code point
    logic eos_ok;

    u8d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    u8d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (head_cmd),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_code_point    (o_code_point),
        .o_end_of_string (o_end_of_string),
        .o_last_of_run   (o_last_of_run)
    );

    assign eos_ok = o_last_of_run && (o_code_point == '0);

    // end marker is always the final result of its byte and carries zero
    `U8D_ASSERT_IMP(a_eos_last, i_clk, i_rst_n, o_out_valid && o_end_of_string, eos_ok)
    // only replacements can precede the final result of a byte
    `U8D_ASSERT_IMP(a_mid_repl, i_clk, i_rst_n, o_out_valid && !o_last_of_run, o_code_point == REPL_CHAR)
    // a command is never written into a full queue
    `U8D_ASSERT_IMP(a_no_ovf, i_clk, i_rst_n, q_push, !q_full)
    // a queued command with results reaches the output register next cycle
    `U8D_ASSERT_NXT(a_drain, i_clk, i_rst_n, q_valid && !o_out_valid, o_out_valid)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for utf8_to_code_point_decoder_core
// Streams UTF-8 bytes (well-formed, broken and random) into the decoder,
// predicts every code point, replacement and end marker in a scoreboard,
// and checks each output transfer in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

    import u8d_pkg::*;

    localparam int unsigned RANDOM_BYTES = 200;
    localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no transfer
    localparam int unsigned DRAIN_CYCLES = 8;     // idle cycles after the scoreboard empties

    // One predicted or observed output transfer.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_string;
        logic            last_of_run;
    } t_code_point_result;

    // ------------------------------------------------------------------------
    // Scoreboard: carries its own copy of the decoder state and turns every
    // accepted byte into the code point results it should produce.
    // ------------------------------------------------------------------------
    class t_code_point_scoreboard;
        logic [2:0]         seq_len;     // LEN_NONE when no sequence pending
        logic [2:0]         seq_taken;   // bytes of the sequence so far
        logic [CP_W-1:0]    seq_bits;    // code point bits gathered so far
        t_code_point_result pending_code_points[$];
        int unsigned        mismatches;
        int unsigned        results_checked;
        int unsigned        replacements;
        int unsigned        strings_ended;

        function new();
            seq_len         = LEN_NONE;
            seq_taken       = 3'd0;
            seq_bits        = '0;
            mismatches      = 0;
            results_checked = 0;
            replacements    = 0;
            strings_ended   = 0;
        endfunction

        function int unsigned pending_count();
            return pending_code_points.size();
        endfunction

        function void push_result(logic [CP_W-1:0] cp, logic eos);
            t_code_point_result r;
            r.code_point    = cp;
            r.end_of_string = eos;
            r.last_of_run   = 1'b0;
            pending_code_points.push_back(r);
        endfunction

        // Predict the results of one accepted byte.
        function void note_byte(logic [7:0] b);
            int unsigned q_size_before;
            bit          as_lead;
            q_size_before = pending_code_points.size();
            as_lead       = 1'b1;

            if (seq_len != LEN_NONE) begin
                if (b[7:6] == 2'b10) begin
                    // continuation: shift six payload bits in
                    as_lead   = 1'b0;
                    seq_bits  = {seq_bits[CP_W-7:0], b[5:0]};
                    seq_taken = seq_taken + 3'd1;
                    if (seq_taken >= seq_len) begin
                        push_result(seq_bits, 1'b0);
                        seq_len   = LEN_NONE;
                        seq_taken = 3'd0;
                        seq_bits  = '0;
                    end
                end else begin
                    // broken sequence: one '?' per byte taken, then re-lead
                    for (int k = 0; k < seq_taken && k < 6; k++)
                        push_result(REPL_CHAR, 1'b0);
                    seq_len   = LEN_NONE;
                    seq_taken = 3'd0;
                    seq_bits  = '0;
                end
            end

            if (as_lead) begin
                if (b == 8'h00) begin
                    push_result('0, 1'b1);
                end else if (b < 8'h80) begin
                    push_result(CP_W'(b), 1'b0);
                end else if (b < 8'hC0) begin
                    push_result(REPL_CHAR, 1'b0);      // stray continuation
                end else if (b < 8'hE0) begin
                    seq_len = LEN_2; seq_taken = 3'd1; seq_bits = CP_W'(b[4:0]);
                end else if (b < 8'hF0) begin
                    seq_len = LEN_3; seq_taken = 3'd1; seq_bits = CP_W'(b[3:0]);
                end else if (b < 8'hF8) begin
                    seq_len = LEN_4; seq_taken = 3'd1; seq_bits = CP_W'(b[2:0]);
                end else if (b < 8'hFC) begin
                    seq_len = LEN_5; seq_taken = 3'd1; seq_bits = CP_W'(b[1:0]);
                end else if (b < 8'hFE) begin
                    seq_len = LEN_6; seq_taken = 3'd1; seq_bits = CP_W'(b[0]);
                end else begin
                    push_result(REPL_CHAR, 1'b0);      // 0xFE / 0xFF
                end
            end

            if (pending_code_points.size() > q_size_before)
                pending_code_points[pending_code_points.size()-1].last_of_run = 1'b1;
        endfunction

        // Compare one output transfer with the oldest prediction.
        function void check_result(logic [CP_W-1:0] cp, logic eos, logic last_of_run);
            t_code_point_result exp_r;
            results_checked++;
            if (pending_code_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result cp=%0h eos=%0b last=%0b",
                             cp, eos, last_of_run);
                return;
            end
            exp_r = pending_code_points.pop_front();
            if (exp_r.code_point == REPL_CHAR && !exp_r.end_of_string)
                replacements++;
            if (exp_r.end_of_string)
                strings_ended++;
            if (cp !== exp_r.code_point || eos !== exp_r.end_of_string ||
                last_of_run !== exp_r.last_of_run) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: cp exp %0h got %0h, eos exp %0b got %0b, last exp %0b got %0b",
                             exp_r.code_point, cp, exp_r.end_of_string, eos,
                             exp_r.last_of_run, last_of_run);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic [7:0]      i_in_byte   = 8'h00;
    logic            i_out_ready = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    logic [CP_W-1:0] o_code_point;
    logic            o_end_of_string;
    logic            o_last_of_run;

    t_code_point_scoreboard sb = new();

    bit          quiet = 1'b0;       // set during the stretch with no idling
    int unsigned bytes_sent = 0;
    int unsigned idle_cycles = 0;

    // short directed string: ends, ASCII extremes, stray and bad leads,
    // a two-byte form, max three/six-byte forms, a lead cut by ASCII, a zero mid-sequence
    logic [7:0] directed_bytes[$] = '{
        8'h00, 8'h7F, 8'h80, 8'hFF, 8'hFE,
        8'hC3, 8'hBF,
        8'hEF, 8'hBF, 8'hBF,
        8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'hF8, 8'h41,
        8'hF4, 8'h80, 8'h80, 8'h00
    };

    utf8_to_code_point_decoder_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_code_point    (o_code_point),
        .o_end_of_string (o_end_of_string),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: ready goes low at random with a chance of about 15 percent, never during quiet.
    always @(posedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= 15);
    end

    // Output monitor: every transfer goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_code_point, o_end_of_string, o_last_of_run);
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    // Drive one byte: random idle gaps first, then hold valid until transfer.
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_lead(input int unsigned len);
        case (len)
            1:       return 8'($urandom_range(1, 127));
            2:       return 8'hC0 | 8'($urandom_range(0, 31));
            3:       return 8'hE0 | 8'($urandom_range(0, 15));
            4:       return 8'hF0 | 8'($urandom_range(0, 7));
            5:       return 8'hF8 | 8'($urandom_range(0, 3));
            default: return 8'hFC | 8'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Stimulus
    initial begin
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        logic [7:0]  b;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // hold the sender off until the decoder has drained completely
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        @(posedge i_clk);

        while (bytes_sent < directed_bytes.size() + RANDOM_BYTES) begin
            quiet = (bytes_sent >= 90 && bytes_sent < 140);
            kind  = $urandom_range(99);
            if (kind < 62) begin
                // well-formed character, shorter forms more often
                len = ($urandom_range(1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 6);
                send_byte(rand_lead(len));
                for (int k = 1; k < len; k++)
                    send_byte(rand_cont());
            end else if (kind < 72) begin
                send_byte(8'h00);              // end of string
            end else if (kind < 86) begin
                // broken sequence: lead, some continuations, then a non-continuation
                len = $urandom_range(2, 6);
                cut = $urandom_range(0, len - 2);
                send_byte(rand_lead(len));
                for (int k = 0; k < cut; k++)
                    send_byte(rand_cont());
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                send_byte(b);
            end else begin
                send_byte(8'($urandom_range(0, 255)));   // raw noise
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes with 1..6 byte forms, broken and stray input",
                 bytes_sent);
        $display("checked %0d results: %0d replacements, %0d end markers",
                 sb.results_checked, sb.replacements, sb.strings_ended);
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     sb.mismatches, sb.pending_count());
            $display("tb failed");
        end
        $finish;
    end

endmodule
